>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies an expression in the next cycle
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hdl/lxfd_pkg.sv
// ----------------------------------------------------------------------------
// lxfd_pkg
// Types and constants for the length/XOR frame deframer.
// ----------------------------------------------------------------------------
package lxfd_pkg;

    // Stream byte width
    localparam int BYTE_W = 8;

    // Configuration register file
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

    localparam logic [CFG_W-1:0] MIN_LEN_RST = 6'd8;
    localparam logic [CFG_W-1:0] MAX_LEN_RST = 6'd40;

    // Shortest legal frame: length byte, one payload byte, check byte
    localparam logic [BYTE_W-1:0] LEN_FLOOR = 8'd3;

    // Default window depth
    localparam int WINDOW_DEPTH_DEF = 40;

    // Scan sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEN,
        ST_CHECK,
        ST_EMIT
    } lxfd_state_t;

endpackage

>>> hdl/lxfd_stream_if.sv
// ----------------------------------------------------------------------------
// lxfd_stream_if
// Valid/ready channels for the raw byte stream and the payload stream.
// ----------------------------------------------------------------------------

// Raw byte channel
interface lxfd_raw_if;
    logic                         valid;
    logic                         ready;
    logic [lxfd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Payload byte channel
interface lxfd_payload_if;
    logic                         valid;
    logic                         ready;
    logic [lxfd_pkg::BYTE_W-1:0]  payload_byte;
    logic                         end_of_frame;

    modport source (output valid, output payload_byte, output end_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input end_of_frame, output ready);
endinterface

>>> hdl/length_xor_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_xor_frame_deframer
// Hunts for length-prefixed frames with an XOR check byte in a byte stream.
// ----------------------------------------------------------------------------
// Each request on raw is appended to a ring window of WINDOW_DEPTH bytes, then
// the front of the window is scanned: a length byte out of the configured
// bounds is dropped, a complete frame whose check byte matches the XOR of the
// length and payload bytes has its payload sent on frame (last byte flagged
// with end_of_frame) and is consumed, and a failed check drops only the
// front byte so the scan restarts one byte later. raw is ready only while
// the sequencer is idle. All window accesses go through one memory port and
// one shared address adder, one byte per cycle while frame is not stalled. After
// each accepted byte the sequencer fetches the front length byte (SCAN, LEN),
// drops it or returns to idle if the candidate is still incomplete; a complete
// candidate is checked byte by byte (CHECK) and, when it matches, its payload
// is read out (EMIT, held while frame is stalled) before the rescan. The window
// needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module length_xor_frame_deframer #(
    parameter int WINDOW_DEPTH = lxfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lxfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lxfd_pkg::CFG_W-1:0]      cfg_data,
    lxfd_raw_if.sink                        raw,
    lxfd_payload_if.source                  frame
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int BW = lxfd_pkg::BYTE_W;

    localparam logic [SW-1:0] DEPTH_S = SW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [BW-1:0] DEPTH_B = BW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // Registers
    lxfd_pkg::lxfd_state_t      state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              len_reg, len_next;
    logic [BW-1:0]              chk_reg, chk_next;
    logic [lxfd_pkg::CFG_W-1:0] min_len_reg, max_len_reg;
    logic [BW-1:0]              rd_data_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [BW-1:0]              out_byte_reg;
    logic                       out_eof_reg;

    // Window memory
    logic [BW-1:0]              window_mem [WINDOW_DEPTH];

    // Datapath controls
    logic [CW-1:0]              off;
    logic [SW-1:0]              addr_sum;
    logic [AW-1:0]              addr;
    logic                       rd_en;
    logic                       wr_en;
    logic                       load_out;
    logic                       raw_fire;
    logic                       slot_free;
    logic [BW-1:0]              lo_len;
    logic [BW-1:0]              hi_len;
    logic                       len_ok;
    logic                       len_short;
    logic                       chk_last;
    logic                       chk_match;
    logic                       emit_last;

    assign raw_fire  = raw.valid && raw.ready;
    assign slot_free = !out_valid_reg || frame.ready;

    // Effective length bounds
    assign lo_len = ({2'b00, min_len_reg} < lxfd_pkg::LEN_FLOOR) ? lxfd_pkg::LEN_FLOOR
                                                                  : {2'b00, min_len_reg};
    assign hi_len = ({2'b00, max_len_reg} > DEPTH_B) ? DEPTH_B : {2'b00, max_len_reg};

    // Scan decisions
    assign len_ok    = (rd_data_reg >= lo_len) && (rd_data_reg <= hi_len);
    assign len_short = {{(9 - CW){1'b0}}, fill_reg} < {1'b0, rd_data_reg};
    assign chk_last  = (k_reg == len_reg - ONE_C);
    assign chk_match = (chk_reg == rd_data_reg);
    assign emit_last = (k_reg == len_reg - TWO_C);

    // Shared ring address adder: head plus offset, wrapped once
    assign addr_sum = {{(SW - AW){1'b0}}, head_reg} + {1'b0, off};
    assign addr     = (addr_sum >= DEPTH_S) ? AW'(addr_sum - DEPTH_S) : AW'(addr_sum);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lxfd_pkg::ST_IDLE:
            begin
                if (raw_fire)
                    state_next = lxfd_pkg::ST_SCAN;
            end
            lxfd_pkg::ST_SCAN:
            begin
                state_next = (fill_reg == '0) ? lxfd_pkg::ST_IDLE : lxfd_pkg::ST_LEN;
            end
            lxfd_pkg::ST_LEN:
            begin
                if (!len_ok)
                    state_next = lxfd_pkg::ST_SCAN;
                else if (len_short)
                    state_next = lxfd_pkg::ST_IDLE;
                else
                    state_next = lxfd_pkg::ST_CHECK;
            end
            lxfd_pkg::ST_CHECK:
            begin
                if (chk_last)
                    state_next = chk_match ? lxfd_pkg::ST_EMIT : lxfd_pkg::ST_SCAN;
            end
            lxfd_pkg::ST_EMIT:
            begin
                if (slot_free && emit_last)
                    state_next = lxfd_pkg::ST_SCAN;
            end
        endcase
    end

    // Datapath controls and next values
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        k_next    = k_reg;
        len_next  = len_reg;
        chk_next  = chk_reg;
        off       = '0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            lxfd_pkg::ST_IDLE:
            begin
                // Append at head + fill; a full window overwrites the front
                off = fill_reg;
                if (raw_fire)
                begin
                    wr_en = 1'b1;
                    if (fill_reg == DEPTH_C)
                        head_next = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                         : head_reg + AW'(1);
                    else
                        fill_next = fill_reg + ONE_C;
                end
            end
            lxfd_pkg::ST_SCAN:
            begin
                // Fetch the candidate length byte
                off   = '0;
                rd_en = (fill_reg != '0);
            end
            lxfd_pkg::ST_LEN:
            begin
                off = ONE_C;
                if (!len_ok)
                begin
                    head_next = addr;
                    fill_next = fill_reg - ONE_C;
                end
                else if (!len_short)
                begin
                    len_next = rd_data_reg[CW-1:0];
                    chk_next = rd_data_reg;
                    k_next   = ONE_C;
                    rd_en    = 1'b1;
                end
            end
            lxfd_pkg::ST_CHECK:
            begin
                if (chk_last)
                begin
                    off = ONE_C;
                    if (chk_match)
                    begin
                        k_next = ONE_C;
                        rd_en  = 1'b1;
                    end
                    else
                    begin
                        head_next = addr;
                        fill_next = fill_reg - ONE_C;
                    end
                end
                else
                begin
                    off      = k_reg + ONE_C;
                    chk_next = chk_reg ^ rd_data_reg;
                    k_next   = k_reg + ONE_C;
                    rd_en    = 1'b1;
                end
            end
            lxfd_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    if (emit_last)
                    begin
                        // Consume the whole frame
                        off       = len_reg;
                        head_next = addr;
                        fill_next = fill_reg - len_reg;
                    end
                    else
                    begin
                        off    = k_reg + ONE_C;
                        k_next = k_reg + ONE_C;
                        rd_en  = 1'b1;
                    end
                end
            end
        endcase
    end

    // Output slot valid
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lxfd_pkg::ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= lxfd_pkg::MIN_LEN_RST;
            max_len_reg <= lxfd_pkg::MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lxfd_pkg::REG_MIN_LEN: min_len_reg <= cfg_data;
                lxfd_pkg::REG_MAX_LEN: max_len_reg <= cfg_data;
            endcase
        end
    end

    // Scan working registers
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        len_reg <= len_next;
        chk_reg <= chk_next;
    end

    // Payload output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg <= rd_data_reg;
            out_eof_reg  <= emit_last;
        end
    end

    // Window memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            window_mem[addr] <= raw.in_byte;
    end

    // Window memory read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= window_mem[addr];
    end

    assign raw.ready          = (state_reg == lxfd_pkg::ST_IDLE);
    assign frame.valid        = out_valid_reg;
    assign frame.payload_byte = out_byte_reg;
    assign frame.end_of_frame = out_eof_reg;

    // Checks
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= DEPTH_C, "window fill exceeds depth")
    `ASSERT_IMPLIES_NEXT(a_busy_after_accept, clk, rst_n, raw.valid && raw.ready, !raw.ready && fill_reg != '0, "accepted byte not buffered")
    `ASSERT_ALWAYS(a_emit_in_frame, clk, rst_n, state_reg != lxfd_pkg::ST_EMIT || (len_reg >= CW'(3) && k_reg <= len_reg - TWO_C && len_reg <= fill_reg), "payload index outside frame")

endmodule
